/* design/rv64_instruction_decoder_assert.svh */
// Assertion macros shared by the decoder's checker.
// Needs a signal named clock and a signal named reset in the including scope.
`ifndef RV64_INSTRUCTION_DECODER_ASSERT_SVH
`define RV64_INSTRUCTION_DECODER_ASSERT_SVH

// Checked at every clock edge outside reset.
`define RV64DEC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define RV64DEC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* design/rv64dec_pkg.sv */
// Types and constants of the RV64 instruction decoder.
// Used by the decode logic, the top level and the checker; depends on nothing.
package rv64dec_pkg;

   typedef enum logic [6:0] {
      OP_NONE      = 7'd0,
      OP_ADD       = 7'd1,
      OP_SUB       = 7'd2,
      OP_SLL       = 7'd3,
      OP_SLT       = 7'd4,
      OP_SLTU      = 7'd5,
      OP_XOR       = 7'd6,
      OP_SRL       = 7'd7,
      OP_SRA       = 7'd8,
      OP_OR        = 7'd9,
      OP_AND       = 7'd10,
      OP_MUL       = 7'd11,
      OP_MULH      = 7'd12,
      OP_MULHSU    = 7'd13,
      OP_MULHU     = 7'd14,
      OP_DIV       = 7'd15,
      OP_DIVU      = 7'd16,
      OP_REM       = 7'd17,
      OP_REMU      = 7'd18,
      OP_ADDI      = 7'd19,
      OP_SLTI      = 7'd20,
      OP_SLTIU     = 7'd21,
      OP_XORI      = 7'd22,
      OP_ORI       = 7'd23,
      OP_ANDI      = 7'd24,
      OP_SLLI      = 7'd25,
      OP_SRLI      = 7'd26,
      OP_SRAI      = 7'd27,
      OP_LUI       = 7'd28,
      OP_AUIPC     = 7'd29,
      OP_JAL       = 7'd30,
      OP_JALR      = 7'd31,
      OP_RET       = 7'd32,
      OP_BEQ       = 7'd33,
      OP_BNE       = 7'd34,
      OP_BLT       = 7'd35,
      OP_BGE       = 7'd36,
      OP_BLTU      = 7'd37,
      OP_BGEU      = 7'd38,
      OP_LB        = 7'd39,
      OP_LH        = 7'd40,
      OP_LW        = 7'd41,
      OP_LD        = 7'd42,
      OP_LBU       = 7'd43,
      OP_LHU       = 7'd44,
      OP_LWU       = 7'd45,
      OP_SB        = 7'd46,
      OP_SH        = 7'd47,
      OP_SW        = 7'd48,
      OP_SD        = 7'd49,
      OP_ECALL     = 7'd50,
      OP_EBREAK    = 7'd51,
      OP_ADDIW     = 7'd52,
      OP_SLLIW     = 7'd53,
      OP_SRLIW     = 7'd54,
      OP_SRAIW     = 7'd55,
      OP_ADDW      = 7'd56,
      OP_SUBW      = 7'd57,
      OP_SLLW      = 7'd58,
      OP_SRLW      = 7'd59,
      OP_SRAW      = 7'd60,
      OP_FLW       = 7'd61,
      OP_FLD       = 7'd62,
      OP_FSW       = 7'd63,
      OP_FSD       = 7'd64,
      OP_FADD_S    = 7'd65,
      OP_FSUB_S    = 7'd66,
      OP_FMUL_S    = 7'd67,
      OP_FDIV_S    = 7'd68,
      OP_FSQRT_S   = 7'd69,
      OP_FMIN_S    = 7'd70,
      OP_FMAX_S    = 7'd71,
      OP_FADD_D    = 7'd72,
      OP_FSUB_D    = 7'd73,
      OP_FMUL_D    = 7'd74,
      OP_FDIV_D    = 7'd75,
      OP_FSQRT_D   = 7'd76,
      OP_FMIN_D    = 7'd77,
      OP_FMAX_D    = 7'd78,
      OP_FEQ_S     = 7'd79,
      OP_FLT_S     = 7'd80,
      OP_FLE_S     = 7'd81,
      OP_FEQ_D     = 7'd82,
      OP_FLT_D     = 7'd83,
      OP_FLE_D     = 7'd84,
      OP_FMV_W_X   = 7'd85,
      OP_FMV_X_W   = 7'd86,
      OP_FMV_D_X   = 7'd87,
      OP_FMV_X_D   = 7'd88,
      OP_FCVT_S_W  = 7'd89,
      OP_FCVT_S_WU = 7'd90,
      OP_FCVT_S_L  = 7'd91,
      OP_FCVT_S_LU = 7'd92,
      OP_FCVT_W_S  = 7'd93,
      OP_FCVT_WU_S = 7'd94,
      OP_FCVT_L_S  = 7'd95,
      OP_FCVT_LU_S = 7'd96,
      OP_FCVT_S_D  = 7'd97,
      OP_FCVT_D_S  = 7'd98,
      OP_FSGNJ_S   = 7'd99,
      OP_FSGNJN_S  = 7'd100,
      OP_FSGNJX_S  = 7'd101,
      OP_FSGNJ_D   = 7'd102,
      OP_FSGNJN_D  = 7'd103,
      OP_FSGNJX_D  = 7'd104
   } op_type;

   // Operation tables indexed by a three-bit selector field.
   typedef op_type op_table_type [8];

   localparam op_table_type ALU_OPS = '{OP_ADD, OP_SLL, OP_SLT, OP_SLTU,
                                        OP_XOR, OP_SRL, OP_OR, OP_AND};
   localparam op_table_type MULDIV_OPS = '{OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU,
                                           OP_DIV, OP_DIVU, OP_REM, OP_REMU};
   localparam op_table_type OPIMM_OPS = '{OP_ADDI, OP_NONE, OP_SLTI, OP_SLTIU,
                                          OP_XORI, OP_NONE, OP_ORI, OP_ANDI};
   localparam op_table_type BRANCH_OPS = '{OP_BEQ, OP_BNE, OP_NONE, OP_NONE,
                                           OP_BLT, OP_BGE, OP_BLTU, OP_BGEU};
   localparam op_table_type LOAD_OPS = '{OP_LB, OP_LH, OP_LW, OP_LD,
                                         OP_LBU, OP_LHU, OP_LWU, OP_NONE};
   localparam op_table_type STORE_OPS = '{OP_SB, OP_SH, OP_SW, OP_SD,
                                          OP_NONE, OP_NONE, OP_NONE, OP_NONE};
   localparam op_table_type FMINMAX_S_OPS = '{OP_FMIN_S, OP_FMAX_S, OP_NONE, OP_NONE,
                                              OP_NONE, OP_NONE, OP_NONE, OP_NONE};
   localparam op_table_type FMINMAX_D_OPS = '{OP_FMIN_D, OP_FMAX_D, OP_NONE, OP_NONE,
                                              OP_NONE, OP_NONE, OP_NONE, OP_NONE};
   localparam op_table_type FCMP_S_OPS = '{OP_FLE_S, OP_FLT_S, OP_FEQ_S, OP_NONE,
                                           OP_NONE, OP_NONE, OP_NONE, OP_NONE};
   localparam op_table_type FCMP_D_OPS = '{OP_FLE_D, OP_FLT_D, OP_FEQ_D, OP_NONE,
                                           OP_NONE, OP_NONE, OP_NONE, OP_NONE};
   localparam op_table_type FSGNJ_S_OPS = '{OP_FSGNJ_S, OP_FSGNJN_S, OP_FSGNJX_S,
                                            OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_NONE};
   localparam op_table_type FSGNJ_D_OPS = '{OP_FSGNJ_D, OP_FSGNJN_D, OP_FSGNJX_D,
                                            OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_NONE};
   localparam op_table_type FCVT_I2F_OPS = '{OP_FCVT_S_W, OP_FCVT_S_WU, OP_FCVT_S_L,
                                             OP_FCVT_S_LU, OP_NONE, OP_NONE, OP_NONE,
                                             OP_NONE};
   localparam op_table_type FCVT_F2I_OPS = '{OP_FCVT_W_S, OP_FCVT_WU_S, OP_FCVT_L_S,
                                             OP_FCVT_LU_S, OP_NONE, OP_NONE, OP_NONE,
                                             OP_NONE};

   // Exact encodings of the two accepted system instructions.
   localparam logic [31:0] ECALL_WORD  = 32'h0000_0073;
   localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;

   typedef struct packed {
      op_type      op_id;
      logic [4:0]  dest_reg;
      logic [4:0]  src1_reg;
      logic [4:0]  src2_reg;
      logic        dest_is_float;
      logic        src1_is_float;
      logic        src2_is_float;
      logic [31:0] immediate;
      logic [63:0] target_addr;
      logic [2:0]  round_mode;
      logic        recognised;
   } dec_result_type;

endpackage

/* design/rv64dec_decode.sv */
// Combinational decode of one RV64IMFD instruction word and its pc.
// Depends on rv64dec_pkg for the operation codes, tables and result struct.
module rv64dec_decode
   import rv64dec_pkg::*;
(
   input  logic [31:0]    instr_word,
   input  logic [63:0]    inst_addr,
   output dec_result_type result
);

   localparam logic [6:0] OPC_LOAD      = 7'h03;
   localparam logic [6:0] OPC_LOAD_FP   = 7'h07;
   localparam logic [6:0] OPC_OP_IMM    = 7'h13;
   localparam logic [6:0] OPC_AUIPC     = 7'h17;
   localparam logic [6:0] OPC_OP_IMM_32 = 7'h1b;
   localparam logic [6:0] OPC_STORE     = 7'h23;
   localparam logic [6:0] OPC_STORE_FP  = 7'h27;
   localparam logic [6:0] OPC_OP        = 7'h33;
   localparam logic [6:0] OPC_LUI       = 7'h37;
   localparam logic [6:0] OPC_OP_32     = 7'h3b;
   localparam logic [6:0] OPC_OP_FP     = 7'h53;
   localparam logic [6:0] OPC_BRANCH    = 7'h63;
   localparam logic [6:0] OPC_JALR      = 7'h67;
   localparam logic [6:0] OPC_JAL       = 7'h6f;
   localparam logic [6:0] OPC_SYSTEM    = 7'h73;

   localparam logic [6:0] F7_BASE   = 7'h00;
   localparam logic [6:0] F7_MULDIV = 7'h01;
   localparam logic [6:0] F7_ALT    = 7'h20;
   localparam logic [5:0] F6_SRL    = 6'h00;
   localparam logic [5:0] F6_SRA    = 6'h10;

   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_WORD = 3'd2;
   localparam logic [2:0] F3_DBL  = 3'd3;
   localparam logic [2:0] F3_SR   = 3'd5;

   localparam logic [6:0] FP_FADD_S  = 7'h00;
   localparam logic [6:0] FP_FADD_D  = 7'h01;
   localparam logic [6:0] FP_FSUB_S  = 7'h04;
   localparam logic [6:0] FP_FSUB_D  = 7'h05;
   localparam logic [6:0] FP_FMUL_S  = 7'h08;
   localparam logic [6:0] FP_FMUL_D  = 7'h09;
   localparam logic [6:0] FP_FDIV_S  = 7'h0c;
   localparam logic [6:0] FP_FDIV_D  = 7'h0d;
   localparam logic [6:0] FP_FSGNJ_S = 7'h10;
   localparam logic [6:0] FP_FSGNJ_D = 7'h11;
   localparam logic [6:0] FP_FMIN_S  = 7'h14;
   localparam logic [6:0] FP_FMIN_D  = 7'h15;
   localparam logic [6:0] FP_CVT_SD  = 7'h20;
   localparam logic [6:0] FP_CVT_DS  = 7'h21;
   localparam logic [6:0] FP_FSQRT_S = 7'h2c;
   localparam logic [6:0] FP_FSQRT_D = 7'h2d;
   localparam logic [6:0] FP_FCMP_S  = 7'h50;
   localparam logic [6:0] FP_FCMP_D  = 7'h51;
   localparam logic [6:0] FP_CVT_F2I = 7'h60;
   localparam logic [6:0] FP_CVT_I2F = 7'h68;
   localparam logic [6:0] FP_MV_X_W  = 7'h70;
   localparam logic [6:0] FP_MV_X_D  = 7'h71;
   localparam logic [6:0] FP_MV_W_X  = 7'h78;
   localparam logic [6:0] FP_MV_D_X  = 7'h79;

   localparam logic [4:0] RS2_CVT_FROM_D = 5'd1;
   localparam logic [4:0] REG_RA         = 5'd1;

   // Register use pattern of a floating-point operation.
   typedef enum logic [3:0] {
      FK_BIN_RM,
      FK_BIN,
      FK_CMP,
      FK_UNARY,
      FK_I2F_MV,
      FK_F2I_MV,
      FK_I2F_CVT,
      FK_F2I_CVT
   } fp_kind_type;

   logic [6:0]  opc;
   logic [4:0]  rd;
   logic [4:0]  rs1;
   logic [4:0]  rs2;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [5:0]  f6;
   logic [31:0] imm_i;
   logic [31:0] imm_s;
   logic [31:0] imm_b;
   logic [31:0] imm_u;
   logic [31:0] imm_j;
   logic [31:0] shamt6;
   logic [31:0] shamt5;
   logic        rs2_zero;
   logic        rs2_small;

   op_type      op;
   fp_kind_type kind;
   logic [4:0]  o_rd;
   logic [4:0]  o_r1;
   logic [4:0]  o_r2;
   logic        fd;
   logic        fs1;
   logic        fs2;
   logic [2:0]  rm;
   logic [31:0] imm;
   logic        rel;
   logic        hit;

   assign opc = instr_word[6:0];
   assign rd  = instr_word[11:7];
   assign f3  = instr_word[14:12];
   assign rs1 = instr_word[19:15];
   assign rs2 = instr_word[24:20];
   assign f7  = instr_word[31:25];
   assign f6  = instr_word[31:26];

   assign imm_i  = {{20{instr_word[31]}}, instr_word[31:20]};
   assign imm_s  = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
   assign imm_b  = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
                    instr_word[30:25], instr_word[11:8], 1'b0};
   assign imm_u  = {instr_word[31:12], 12'b0};
   assign imm_j  = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
                    instr_word[20], instr_word[30:21], 1'b0};
   assign shamt6 = {26'b0, instr_word[25:20]};
   assign shamt5 = {27'b0, rs2};

   assign rs2_zero  = (rs2 == 5'd0);
   assign rs2_small = (rs2[4:2] == 3'b000);

   // Floating-point sub-decode: operation and register use pattern by funct7.
   always_comb begin
      op_type fop;
      fp_kind_type fkind;
      fop   = OP_NONE;
      fkind = FK_BIN;
      unique case (f7)
         FP_FADD_S:  begin fop = OP_FADD_S; fkind = FK_BIN_RM; end
         FP_FSUB_S:  begin fop = OP_FSUB_S; fkind = FK_BIN_RM; end
         FP_FMUL_S:  begin fop = OP_FMUL_S; fkind = FK_BIN_RM; end
         FP_FDIV_S:  begin fop = OP_FDIV_S; fkind = FK_BIN_RM; end
         FP_FADD_D:  begin fop = OP_FADD_D; fkind = FK_BIN_RM; end
         FP_FSUB_D:  begin fop = OP_FSUB_D; fkind = FK_BIN_RM; end
         FP_FMUL_D:  begin fop = OP_FMUL_D; fkind = FK_BIN_RM; end
         FP_FDIV_D:  begin fop = OP_FDIV_D; fkind = FK_BIN_RM; end
         FP_FSQRT_S: begin
            fop   = rs2_zero ? OP_FSQRT_S : OP_NONE;
            fkind = FK_UNARY;
         end
         FP_FSQRT_D: begin
            fop   = rs2_zero ? OP_FSQRT_D : OP_NONE;
            fkind = FK_UNARY;
         end
         FP_FMIN_S:  begin fop = FMINMAX_S_OPS[f3]; fkind = FK_BIN; end
         FP_FMIN_D:  begin fop = FMINMAX_D_OPS[f3]; fkind = FK_BIN; end
         FP_FCMP_S:  begin fop = FCMP_S_OPS[f3]; fkind = FK_CMP; end
         FP_FCMP_D:  begin fop = FCMP_D_OPS[f3]; fkind = FK_CMP; end
         FP_MV_W_X:  begin
            fop   = (rs2_zero && f3 == F3_ADD) ? OP_FMV_W_X : OP_NONE;
            fkind = FK_I2F_MV;
         end
         FP_MV_D_X:  begin
            fop   = (rs2_zero && f3 == F3_ADD) ? OP_FMV_D_X : OP_NONE;
            fkind = FK_I2F_MV;
         end
         FP_MV_X_W:  begin
            fop   = (rs2_zero && f3 == F3_ADD) ? OP_FMV_X_W : OP_NONE;
            fkind = FK_F2I_MV;
         end
         FP_MV_X_D:  begin
            fop   = (rs2_zero && f3 == F3_ADD) ? OP_FMV_X_D : OP_NONE;
            fkind = FK_F2I_MV;
         end
         FP_CVT_I2F: begin
            fop   = rs2_small ? FCVT_I2F_OPS[rs2[2:0]] : OP_NONE;
            fkind = FK_I2F_CVT;
         end
         FP_CVT_F2I: begin
            fop   = rs2_small ? FCVT_F2I_OPS[rs2[2:0]] : OP_NONE;
            fkind = FK_F2I_CVT;
         end
         FP_CVT_SD:  begin
            fop   = (rs2 == RS2_CVT_FROM_D) ? OP_FCVT_S_D : OP_NONE;
            fkind = FK_UNARY;
         end
         FP_CVT_DS:  begin
            fop   = rs2_zero ? OP_FCVT_D_S : OP_NONE;
            fkind = FK_UNARY;
         end
         FP_FSGNJ_S: begin fop = FSGNJ_S_OPS[f3]; fkind = FK_BIN; end
         FP_FSGNJ_D: begin fop = FSGNJ_D_OPS[f3]; fkind = FK_BIN; end
         default:    begin fop = OP_NONE; fkind = FK_BIN; end
      endcase
      kind = fkind;
      if (opc == OPC_OP_FP) begin
         hit = 1'b1;
      end else begin
         hit = 1'b0;
      end
      op = hit ? fop : OP_NONE;
   end

   always_comb begin
      op_type dop;
      dop  = OP_NONE;
      o_rd = 5'd0;
      o_r1 = 5'd0;
      o_r2 = 5'd0;
      fd   = 1'b0;
      fs1  = 1'b0;
      fs2  = 1'b0;
      rm   = 3'd0;
      imm  = 32'd0;
      rel  = 1'b0;
      unique case (opc)
         OPC_OP: begin
            if (f7 == F7_MULDIV) begin
               dop = MULDIV_OPS[f3];
            end else if (f7 == F7_BASE) begin
               dop = ALU_OPS[f3];
            end else if (f7 == F7_ALT && f3 == F3_ADD) begin
               dop = OP_SUB;
            end else if (f7 == F7_ALT && f3 == F3_SR) begin
               dop = OP_SRA;
            end
            o_rd = rd;
            o_r1 = rs1;
            o_r2 = rs2;
         end
         OPC_OP_IMM: begin
            imm = imm_i;
            dop = OPIMM_OPS[f3];
            if (f3 == F3_SLL) begin
               imm = shamt6;
               dop = (f6 == F6_SRL) ? OP_SLLI : OP_NONE;
            end else if (f3 == F3_SR) begin
               imm = shamt6;
               if (f6 == F6_SRL) begin
                  dop = OP_SRLI;
               end else if (f6 == F6_SRA) begin
                  dop = OP_SRAI;
               end else begin
                  dop = OP_NONE;
               end
            end
            o_rd = rd;
            o_r1 = rs1;
         end
         OPC_LUI: begin
            dop  = OP_LUI;
            o_rd = rd;
            imm  = imm_u;
         end
         OPC_AUIPC: begin
            dop  = OP_AUIPC;
            o_rd = rd;
            imm  = imm_u;
            rel  = 1'b1;
         end
         OPC_JAL: begin
            dop  = OP_JAL;
            o_rd = rd;
            imm  = imm_j;
            rel  = 1'b1;
         end
         OPC_JALR: begin
            // The canonical return is jalr x0, 0(ra).
            if (f3 == F3_ADD) begin
               dop = (rd == 5'd0 && rs1 == REG_RA && imm_i == 32'd0) ? OP_RET : OP_JALR;
            end
            o_rd = rd;
            o_r1 = rs1;
            imm  = imm_i;
         end
         OPC_BRANCH: begin
            dop  = BRANCH_OPS[f3];
            o_r1 = rs1;
            o_r2 = rs2;
            imm  = imm_b;
            rel  = 1'b1;
         end
         OPC_LOAD: begin
            dop  = LOAD_OPS[f3];
            o_rd = rd;
            o_r1 = rs1;
            imm  = imm_i;
         end
         OPC_STORE: begin
            dop  = STORE_OPS[f3];
            o_r1 = rs1;
            o_r2 = rs2;
            imm  = imm_s;
         end
         OPC_SYSTEM: begin
            if (instr_word == ECALL_WORD) begin
               dop = OP_ECALL;
            end else if (instr_word == EBREAK_WORD) begin
               dop = OP_EBREAK;
            end
         end
         OPC_OP_IMM_32: begin
            imm = imm_i;
            if (f3 == F3_ADD) begin
               dop = OP_ADDIW;
            end else if (f3 == F3_SLL) begin
               imm = shamt5;
               dop = (f7 == F7_BASE) ? OP_SLLIW : OP_NONE;
            end else if (f3 == F3_SR) begin
               imm = shamt5;
               if (f7 == F7_BASE) begin
                  dop = OP_SRLIW;
               end else if (f7 == F7_ALT) begin
                  dop = OP_SRAIW;
               end
            end
            o_rd = rd;
            o_r1 = rs1;
         end
         OPC_OP_32: begin
            if (f3 == F3_ADD && f7 == F7_BASE) begin
               dop = OP_ADDW;
            end else if (f3 == F3_ADD && f7 == F7_ALT) begin
               dop = OP_SUBW;
            end else if (f3 == F3_SLL && f7 == F7_BASE) begin
               dop = OP_SLLW;
            end else if (f3 == F3_SR && f7 == F7_BASE) begin
               dop = OP_SRLW;
            end else if (f3 == F3_SR && f7 == F7_ALT) begin
               dop = OP_SRAW;
            end
            o_rd = rd;
            o_r1 = rs1;
            o_r2 = rs2;
         end
         OPC_LOAD_FP: begin
            if (f3 == F3_WORD) begin
               dop = OP_FLW;
            end else if (f3 == F3_DBL) begin
               dop = OP_FLD;
            end
            o_rd = rd;
            fd   = 1'b1;
            o_r1 = rs1;
            imm  = imm_i;
         end
         OPC_STORE_FP: begin
            if (f3 == F3_WORD) begin
               dop = OP_FSW;
            end else if (f3 == F3_DBL) begin
               dop = OP_FSD;
            end
            o_r1 = rs1;
            o_r2 = rs2;
            fs2  = 1'b1;
            imm  = imm_s;
         end
         OPC_OP_FP: begin
            dop  = op;
            o_rd = rd;
            o_r1 = rs1;
            unique case (kind)
               FK_BIN_RM: begin
                  o_r2 = rs2; fs1 = 1'b1; fs2 = 1'b1; fd = 1'b1; rm = f3;
               end
               FK_BIN: begin
                  o_r2 = rs2; fs1 = 1'b1; fs2 = 1'b1; fd = 1'b1;
               end
               FK_CMP: begin
                  o_r2 = rs2; fs1 = 1'b1; fs2 = 1'b1;
               end
               FK_UNARY: begin
                  fd = 1'b1; fs1 = 1'b1; rm = f3;
               end
               FK_I2F_MV: begin
                  fd = 1'b1;
               end
               FK_I2F_CVT: begin
                  fd = 1'b1; rm = f3;
               end
               FK_F2I_MV: begin
                  fs1 = 1'b1;
               end
               FK_F2I_CVT: begin
                  fs1 = 1'b1; rm = f3;
               end
               default: begin
                  fs1 = 1'b0;
               end
            endcase
         end
         default: begin
            dop = OP_NONE;
         end
      endcase

      // An unrecognised word reports nothing but zeros.
      if (dop == OP_NONE) begin
         result = '0;
      end else begin
         result.op_id         = dop;
         result.dest_reg      = o_rd;
         result.src1_reg      = o_r1;
         result.src2_reg      = o_r2;
         result.dest_is_float = fd;
         result.src1_is_float = fs1;
         result.src2_is_float = fs2;
         result.immediate     = imm;
         result.target_addr   = rel ? (inst_addr + {{32{imm[31]}}, imm}) : 64'd0;
         result.round_mode    = rm;
         result.recognised    = 1'b1;
      end
   end

endmodule

/* design/rv64_instruction_decoder.sv */
// Top level of the RV64 instruction decoder: request register, decode, result register.
// Depends on rv64dec_pkg and rv64dec_decode.
//
// Decodes one RV64IMFD instruction word per clock while results are being taken.
// A request is captured in an input register, then decoded and its pc-relative target
// added (one 64-bit adder), and the result is held in an output register, so a new
// request is taken every cycle while results are being taken. When the result side
// stalls, the two registers fill and req_ready drops; it rises in the same cycle that
// rsp_ready frees a slot.
// Unrecognized encodings give op_id 0 and all other fields 0.
module rv64_instruction_decoder
   import rv64dec_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_instr_word,
   input  logic [63:0]        req_inst_addr,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [6:0]         rsp_op_id,
   output logic [4:0]         rsp_dest_reg,
   output logic [4:0]         rsp_src1_reg,
   output logic [4:0]         rsp_src2_reg,
   output logic               rsp_dest_is_float,
   output logic               rsp_src1_is_float,
   output logic               rsp_src2_is_float,
   output logic signed [31:0] rsp_immediate,
   output logic [63:0]        rsp_target_addr,
   output logic [2:0]         rsp_round_mode,
   output logic               rsp_recognised
);

   logic           in_valid_ff;
   logic           in_valid_in;
   logic [31:0]    in_word_ff;
   logic [63:0]    in_addr_ff;
   logic           out_valid_ff;
   logic           out_valid_in;
   dec_result_type out_res_ff;
   dec_result_type dec_res;
   logic           out_free;
   logic           in_free;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign in_free   = !in_valid_ff || out_free;
   assign req_ready = in_free;

   assign in_valid_in  = in_free ? req_valid : in_valid_ff;
   assign out_valid_in = out_free ? in_valid_ff : out_valid_ff;

   rv64dec_decode u_decode (
      .instr_word (in_word_ff),
      .inst_addr  (in_addr_ff),
      .result     (dec_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && in_free) begin
         in_word_ff <= req_instr_word;
         in_addr_ff <= req_inst_addr;
      end
      if (in_valid_ff && out_free) begin
         out_res_ff <= dec_res;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_op_id         = out_res_ff.op_id;
   assign rsp_dest_reg      = out_res_ff.dest_reg;
   assign rsp_src1_reg      = out_res_ff.src1_reg;
   assign rsp_src2_reg      = out_res_ff.src2_reg;
   assign rsp_dest_is_float = out_res_ff.dest_is_float;
   assign rsp_src1_is_float = out_res_ff.src1_is_float;
   assign rsp_src2_is_float = out_res_ff.src2_is_float;
   assign rsp_immediate     = $signed(out_res_ff.immediate);
   assign rsp_target_addr   = out_res_ff.target_addr;
   assign rsp_round_mode    = out_res_ff.round_mode;
   assign rsp_recognised    = out_res_ff.recognised;

endmodule

/* design/rv64dec_checker.sv */
// Port-level checks of the RV64 instruction decoder, bound to its top level.
// Depends on rv64dec_pkg and the macros in rv64_instruction_decoder_assert.svh.
`include "rv64_instruction_decoder_assert.svh"

module rv64dec_port_checks
   import rv64dec_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [6:0]         rsp_op_id,
   input logic [4:0]         rsp_dest_reg,
   input logic [4:0]         rsp_src1_reg,
   input logic [4:0]         rsp_src2_reg,
   input logic               rsp_dest_is_float,
   input logic               rsp_src1_is_float,
   input logic               rsp_src2_is_float,
   input logic signed [31:0] rsp_immediate,
   input logic [63:0]        rsp_target_addr,
   input logic [2:0]         rsp_round_mode,
   input logic               rsp_recognised
);

   logic rsp_all_zero;
   logic rsp_pc_rel;

   assign rsp_all_zero = (rsp_dest_reg == 5'd0) && (rsp_src1_reg == 5'd0) &&
                         (rsp_src2_reg == 5'd0) && !rsp_dest_is_float &&
                         !rsp_src1_is_float && !rsp_src2_is_float &&
                         (rsp_immediate == 32'sd0) && (rsp_target_addr == 64'd0) &&
                         (rsp_round_mode == 3'd0);

   assign rsp_pc_rel = (rsp_op_id == OP_AUIPC) || (rsp_op_id == OP_JAL) ||
                       (rsp_op_id == OP_BEQ) || (rsp_op_id == OP_BNE) ||
                       (rsp_op_id == OP_BLT) || (rsp_op_id == OP_BGE) ||
                       (rsp_op_id == OP_BLTU) || (rsp_op_id == OP_BGEU);

   `RV64DEC_ASSERT_ALWAYS(a_idle_after_reset, reset |=> !rsp_valid, "result valid right after reset")
   `RV64DEC_ASSERT(a_recognised_flag, rsp_valid |-> (rsp_recognised == (rsp_op_id != OP_NONE)), "recognized flag disagrees with op_id")
   `RV64DEC_ASSERT(a_unknown_zero, (rsp_valid && !rsp_recognised) |-> rsp_all_zero, "unrecognized word with nonzero fields")
   `RV64DEC_ASSERT(a_target_only_rel, (rsp_valid && rsp_target_addr != 64'd0) |-> rsp_pc_rel, "target given for an operation without one")
   `RV64DEC_ASSERT(a_stall_holds, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_op_id) && $stable(rsp_target_addr)), "stalled result changed")

endmodule

bind rv64_instruction_decoder rv64dec_port_checks u_rv64dec_port_checks (.*);
